>>> rtl/llsa_pkg.sv
// Shared types and constants for the least-loaded server assignment block.
// Used by llsa_heap_mem and least_loaded_server_assign; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package llsa_pkg;

  localparam int MAX_SERVERS = 16;
  // heap slot index, server count and child index widths
  localparam int SLOT_W      = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
  localparam int IDX_W       = SLOT_W + 2;
  localparam int LOAD_W      = 32;
  localparam int LEN_W       = 16;
  localparam int SRV_OUT_W   = 4;
  localparam int CFG_W       = 5;
  localparam int CNT_RESET   = (MAX_SERVERS < 16) ? MAX_SERVERS : 16;

  // one heap slot: busy-until time and the server it belongs to
  typedef struct packed {
    logic [LOAD_W-1:0] load;
    logic [SLOT_W-1:0] srv;
  } entry_t;

  // heap memory request from the controller
  typedef struct packed {
    logic              clr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr_a;
    logic [SLOT_W-1:0] raddr_b;
  } mem_req_t;

  // a orders before b: lower busy time, then lower server
  function automatic logic slot_before(input entry_t a, input entry_t b);
    logic r;
    if (a.load != b.load) begin
      r = (a.load < b.load);
    end else begin
      r = (a.srv < b.srv);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/least_loaded_server_assign.sv
// Least-loaded server assignment: after a job is accepted, the root read (S_ROOT)
// loads the result register once the output is not stalled. A job holds the block
// from idle through the root read and then one compare/write step per heap level
// walked; the sift-down through the single heap memory sets how long that takes.
// Reset: 16 servers, all busy times zero. A server count write clears them too.
// Top level: job FSM and result register; storage in llsa_heap_mem (llsa_pkg).
`timescale 1ns / 1ps
`default_nettype none

module least_loaded_server_assign (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [llsa_pkg::CFG_W-1:0]     cfg_server_count_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [llsa_pkg::LEN_W-1:0]     job_length_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [llsa_pkg::SRV_OUT_W-1:0]      server_index_o,
  output logic [llsa_pkg::LOAD_W-1:0]         start_time_o,
  output logic [llsa_pkg::LOAD_W-1:0]         finish_time_o
);
  import llsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROOT,
    S_CMP
  } state_e;

  state_e                 state_q;
  logic [SLOT_W-1:0]      pos_q;
  entry_t                 cur_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [LEN_W-1:0]       len_q;
  logic                   out_valid_q;
  logic [SRV_OUT_W-1:0]   srv_out_q;
  logic [LOAD_W-1:0]      start_q;
  logic [LOAD_W-1:0]      finish_q;

  mem_req_t               req;
  entry_t                 rd_a;
  entry_t                 rd_b;

  logic                   accept;
  logic                   cfg_wr;
  logic                   out_free;
  logic                   out_load;
  logic [LOAD_W:0]        sum;
  logic [LOAD_W-1:0]      fin;
  logic [IDX_W-1:0]       cnt_x;
  logic [IDX_W-1:0]       lidx;
  logic [IDX_W-1:0]       ridx;
  logic                   l_ok;
  logic                   r_ok;
  entry_t                 best;
  logic [SLOT_W-1:0]      best_slot;
  logic                   best_cur;
  logic [IDX_W-1:0]       nl;
  logic [CNT_W-1:0]       cnt_new;

  llsa_heap_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  // a pending count write goes first; the job waits while cfg_valid_i is high
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == S_ROOT) && out_free;

  always_comb begin
    if (cfg_server_count_i == '0) begin
      cnt_new = CNT_W'(1);
    end else if (int'(cfg_server_count_i) > MAX_SERVERS) begin
      cnt_new = CNT_W'(MAX_SERVERS);
    end else begin
      cnt_new = CNT_W'(cfg_server_count_i);
    end
  end

  // saturating finish time of the root job
  assign sum = {1'b0, rd_a.load} + (LOAD_W+1)'(len_q);
  assign fin = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];

  // children of the current slot
  assign cnt_x = IDX_W'(cnt_q);
  assign lidx  = {1'b0, pos_q, 1'b1};
  assign ridx  = lidx + IDX_W'(1);
  assign l_ok  = (lidx < cnt_x);
  assign r_ok  = (ridx < cnt_x);

  always_comb begin
    best      = cur_q;
    best_slot = pos_q;
    best_cur  = 1'b1;
    if (l_ok && slot_before(rd_a, best)) begin
      best      = rd_a;
      best_slot = SLOT_W'(lidx);
      best_cur  = 1'b0;
    end
    if (r_ok && slot_before(rd_b, best)) begin
      best      = rd_b;
      best_slot = SLOT_W'(ridx);
      best_cur  = 1'b0;
    end
  end

  assign nl = {1'b0, best_slot, 1'b1};

  always_comb begin
    req         = '0;
    req.clr     = cfg_wr;
    req.wdata   = cur_q;
    req.waddr   = pos_q;
    case (state_q)
      S_IDLE: begin
        req.re      = accept;
        req.raddr_a = '0;
        req.raddr_b = '0;
      end
      S_ROOT: begin
        // children of the root
        req.re      = out_free && (cnt_x > IDX_W'(1));
        req.raddr_a = SLOT_W'(1);
        req.raddr_b = SLOT_W'(2);
      end
      S_CMP: begin
        req.we = 1'b1;
        if (!best_cur) begin
          // promote the smaller child, keep walking down
          req.wdata   = best;
          req.re      = (nl < cnt_x);
          req.raddr_a = SLOT_W'(nl);
          req.raddr_b = SLOT_W'(nl + IDX_W'(1));
        end
      end
      default: begin
        req.re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      cur_q       <= '0;
      cnt_q       <= CNT_W'(CNT_RESET);
      len_q       <= '0;
      out_valid_q <= 1'b0;
      srv_out_q   <= '0;
      start_q     <= '0;
      finish_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        cnt_q <= cnt_new;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            len_q   <= job_length_i;
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (out_free) begin
            srv_out_q   <= SRV_OUT_W'(rd_a.srv);
            start_q     <= rd_a.load;
            finish_q    <= fin;
            cur_q       <= entry_t'{load: fin, srv: rd_a.srv};
            pos_q       <= '0;
            state_q     <= S_CMP;
          end
        end
        S_CMP: begin
          if (best_cur) begin
            state_q <= S_IDLE;
          end else begin
            pos_q <= best_slot;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign server_index_o = srv_out_q;
  assign start_time_o   = start_q;
  assign finish_time_o  = finish_q;

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.we |-> (IDX_W'(req.waddr) < cnt_x))
    else $error("heap write beyond server count");

  a_accept_to_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_ROOT))
    else $error("accepted word did not start a root read");

  a_finish_ge_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (finish_time_o >= start_time_o))
    else $error("finish time below start time");

  a_sift_moves_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) && !best_cur |=> (state_q == S_CMP) && (pos_q > $past(pos_q)))
    else $error("sift-down did not descend");

endmodule

`default_nettype wire

>>> rtl/llsa_heap_mem.sv
// Heap storage: one write port, two registered read ports, per-slot valid bits.
// An unwritten slot reads as zero load holding its own server. Uses llsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module llsa_heap_mem (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire llsa_pkg::mem_req_t req_i,
  output llsa_pkg::entry_t       rd_a_o,
  output llsa_pkg::entry_t       rd_b_o
);
  import llsa_pkg::*;

  entry_t                 mem [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] vld_q;
  entry_t                 rd_a_q;
  entry_t                 rd_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.clr) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_a_q <= vld_q[req_i.raddr_a] ? mem[req_i.raddr_a]
                                     : entry_t'{load: '0, srv: req_i.raddr_a};
      rd_b_q <= vld_q[req_i.raddr_b] ? mem[req_i.raddr_b]
                                     : entry_t'{load: '0, srv: req_i.raddr_b};
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

`default_nettype wire

>>> sim/tb.sv
// Testbench for least_loaded_server_assign: runs job words through the block and
// compares every result word with a min-heap scheduler kept in the testbench.
// Depends on llsa_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
  import llsa_pkg::*;

  typedef struct packed {
    logic [SRV_OUT_W-1:0] srv;
    logic [LOAD_W-1:0]    start;
    logic [LOAD_W-1:0]    finish;
  } placement_t;

  // quiet cycles tolerated: the long receiver hold plus drain settle, with margin
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PRESSURE_HOLD = 300;
  // max-length jobs on two servers: busy times climb well past 16 bits
  localparam int MAX_LEN_JOBS  = 48;

  logic                 clk_i     = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_count = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [LEN_W-1:0]     job_len   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SRV_OUT_W-1:0] srv_idx;
  logic [LOAD_W-1:0]    start_t;
  logic [LOAD_W-1:0]    finish_t;

  // scheduler state mirrored in the testbench
  logic [LOAD_W-1:0]    srv_key [MAX_SERVERS];
  logic [SRV_OUT_W-1:0] srv_id  [MAX_SERVERS];
  int                   active_servers;

  placement_t           pending_placements[$];
  placement_t           due;
  int                   errors        = 0;
  int                   idle_cycles   = 0;
  int                   gap_max       = 4;
  int                   hold_max      = 4;
  int                   pressure_hold = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  least_loaded_server_assign dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_server_count_i (cfg_count),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .job_length_i       (job_len),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .server_index_o     (srv_idx),
    .start_time_o       (start_t),
    .finish_time_o      (finish_t)
  );

  function automatic bit lighter(int a, int b);
    if (srv_key[a] != srv_key[b]) begin
      return srv_key[a] < srv_key[b];
    end
    return srv_id[a] < srv_id[b];
  endfunction

  function automatic void clear_servers(logic [CFG_W-1:0] count);
    if (count == 0) begin
      active_servers = 1;
    end else if (count > MAX_SERVERS) begin
      active_servers = MAX_SERVERS;
    end else begin
      active_servers = int'(count);
    end
    for (int k = 0; k < MAX_SERVERS; k++) begin
      srv_key[k] = '0;
      srv_id[k]  = SRV_OUT_W'(k);
    end
  endfunction

  // root takes the job, busy time saturates, then the root sinks to its place
  function automatic placement_t place_job(logic [LEN_W-1:0] len);
    placement_t           p;
    logic [LOAD_W:0]      sum;
    logic [LOAD_W-1:0]    tk;
    logic [SRV_OUT_W-1:0] ti;
    int                   pos;
    int                   best;
    bit                   settled;
    p.srv   = srv_id[0];
    p.start = srv_key[0];
    sum     = {1'b0, srv_key[0]} + (LOAD_W+1)'(len);
    p.finish = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
    srv_key[0] = p.finish;
    pos     = 0;
    settled = 1'b0;
    while (!settled) begin
      best = pos;
      for (int c = 2 * pos + 1; c <= 2 * pos + 2; c++) begin
        if (c < active_servers && lighter(c, best)) begin
          best = c;
        end
      end
      if (best == pos) begin
        settled = 1'b1;
      end else begin
        tk = srv_key[pos];
        ti = srv_id[pos];
        srv_key[pos]  = srv_key[best];
        srv_id[pos]   = srv_id[best];
        srv_key[best] = tk;
        srv_id[best]  = ti;
        pos = best;
      end
    end
    return p;
  endfunction

  function automatic void check_field(string name, logic [LOAD_W-1:0] want,
                                      logic [LOAD_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  task automatic send_job(logic [LEN_W-1:0] len);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    job_len  <= len;
    do @(posedge clk_i); while (in_stall);
    pending_placements.push_back(place_job(len));
  endtask

  // stop sending, let every result come out, then give the sift time to finish
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CFG_W-1:0] count);
    drain();
    cfg_count <= count;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    clear_servers(count);
  endtask

  task automatic test_reset_defaults();
    logic [LEN_W-1:0] lens [12] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                     16'h7FFF, 16'h5555, 16'hAAAA, 16'h0000,
                                     16'h0003, 16'h0003, 16'h0003, 16'hFFFF};
    foreach (lens[k]) send_job(lens[k]);
  endtask

  task automatic test_count_limits();
    write_count(CFG_W'(0));        // taken as one server
    send_job(16'd5);
    send_job(16'd5);
    send_job(16'd0);
    write_count(CFG_W'(31));       // clamped to the maximum
    send_job(16'd7);
    send_job(16'd2);
    send_job(16'd0);
    write_count(CFG_W'(17));
    send_job(16'd1);
    send_job(16'd1);
    write_count(CFG_W'(2));
    send_job(16'd9);
    send_job(16'd9);
    send_job(16'd4);
  endtask

  task automatic test_max_length();
    write_count(CFG_W'(2));
    gap_max  = 0;
    hold_max = 0;
    repeat (MAX_LEN_JOBS) send_job(16'hFFFF);
    send_job(16'd0);
    send_job(16'h1234);
    gap_max  = 4;
    hold_max = 4;
  endtask

  task automatic test_backpressure();
    write_count(CFG_W'(3));
    gap_max       = 0;
    pressure_hold = PRESSURE_HOLD;
    repeat (40) send_job(LEN_W'($urandom));
    gap_max = 4;
  endtask

  task automatic test_random_mix();
    logic [CFG_W-1:0] count;
    logic [LEN_W-1:0] len;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        count = CFG_W'(1);
      end else if (phase == 1) begin
        count = CFG_W'(16);
      end else begin
        count = CFG_W'($urandom_range(0, 31));
      end
      write_count(count);
      gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 4;
      hold_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      repeat (80) begin
        case ($urandom_range(0, 9))
          0:          len = '0;
          1:          len = '1;
          2, 3, 4, 5: len = LEN_W'($urandom_range(0, 15));  // lots of equal busy times
          default:    len = LEN_W'($urandom);
        endcase
        send_job(len);
      end
    end
    gap_max  = 4;
    hold_max = 4;
  endtask

  // result side stall pattern; a pressure request turns into one long hold
  initial begin : receiver
    int hold;
    forever begin
      if (pressure_hold > 0) begin
        hold = pressure_hold;
        pressure_hold = 0;
      end else begin
        hold = $urandom_range(0, hold_max);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_placements.size() == 0) begin
        errors++;
        $display("%0t: expected no word, got server %0d start %0d finish %0d",
                 $time, srv_idx, start_t, finish_t);
      end else begin
        due = pending_placements.pop_front();
        check_field("server_index", LOAD_W'(due.srv), LOAD_W'(srv_idx));
        check_field("start_time", due.start, start_t);
        check_field("finish_time", due.finish, finish_t);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    clear_servers(CFG_W'(CNT_RESET));
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_count_limits();
    test_max_length();
    test_backpressure();
    test_random_mix();
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
